[rtl/core/pcst_pkg.sv]
// ============================================================================
// pcst_pkg: shared types and constants of the PC sample profiler
// Sizes, register indexes and the controller/datapath command and status.
// ============================================================================
package pcst_pkg;

    localparam int HIST_WORDS = 4096;
    localparam int TOP_MAX    = 64;
    localparam int KEPT_DEPTH = 64;

    localparam int HW_AW  = (HIST_WORDS > 1) ? $clog2(HIST_WORDS) : 1;
    localparam int HW_CW  = HW_AW + 1;
    localparam int KP_AW  = $clog2(KEPT_DEPTH);
    localparam int KC_W   = KP_AW + 1;
    localparam int ENT_W  = 64;
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_LIMIT = 2'd1;
    localparam logic [31:0]       LIMIT_RST = 32'd16384;

    typedef enum logic [1:0] {
        W_CUR,
        W_BEST,
        W_AENT
    } t_wsel;

    typedef struct packed {
        logic              ld_item;
        logic              hist_we;
        logic              hist_scan;
        logic              hist_clear;
        logic [HW_CW-1:0]  ctr;
        logic              cnt_ld;
        logic              kept_we;
        logic [KP_AW-1:0]  kaddr;
        t_wsel             wsel;
        logic              best_ld;
        logic              a_ld;
        logic              emit_oor;
        logic              emit_entry;
        logic              emit_last;
    } t_cmd;

    typedef struct packed {
        logic              is_dump;
        logic              in_range;
        logic [KC_W-1:0]   n;
        logic              cnt_zero;
        logic              scan_end;
        logic              q_lt_best;
        logic              q_gt_best;
        logic              cur_gt_best;
    } t_sts;

endpackage

[rtl/core/pc_sample_histogram_top_k_core.sv]
// ============================================================================
// pc_sample_histogram_top_k_core: PC sample profiler with top-k dump
// Word-slot sample counter with a sorted top-entry readout.
// ============================================================================
// Usage:
//   Request channel: drive i_op/i_sample_addr/i_top_count with i_start; a
//   request is taken when i_start is high and o_busy is low.
//   Config channel: i_cfg_valid with i_cfg_index/i_cfg_data; o_cfg_ready is
//   always high. Write only while the core is idle.
//   Results: o_valid strobes for one cycle per result; o_last marks the end.
// Operation:
//   After reset the count memory is cleared, with o_busy high. A sample
//   updates its slot with a read and then a write; a rejected sample strobes
//   its result with o_out_of_range set. A dump scans each slot, searches the
//   kept entries for the minimum at each non-zero slot once K entries are
//   kept, then emits the entries by selection sort over the kept set. The
//   single-port count and kept-entry memories serialise these steps.
//   The receiver cannot stall: results are dropped if not taken.
// ============================================================================
module pc_sample_histogram_top_k_core
    import pcst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_op,
    input  logic [31:0]       i_sample_addr,
    input  logic [6:0]        i_top_count,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output logic              o_valid,
    output logic [31:0]       o_entry_addr,
    output logic [31:0]       o_entry_count,
    output logic              o_out_of_range,
    output logic              o_last
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    pcst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    pcst_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_sample_addr  (i_sample_addr),
        .i_top_count    (i_top_count),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_entry_addr   (o_entry_addr),
        .o_entry_count  (o_entry_count),
        .o_out_of_range (o_out_of_range),
        .o_last         (o_last)
    );

endmodule

[rtl/core/pcst_ram.sv]
// ============================================================================
// pcst_ram: generic single-port RAM
// One read or write address per cycle, registered read data.
// ============================================================================
module pcst_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_addr,
    input  logic [W-1:0]                        i_wdata,
    output logic [W-1:0]                        o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;

endmodule

[rtl/core/pcst_dp.sv]
// ============================================================================
// pcst_dp: profiler datapath
// Configuration registers, count and kept-entry memories, compares, outputs.
// ============================================================================
module pcst_dp
    import pcst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_op,
    input  logic [31:0]       i_sample_addr,
    input  logic [6:0]        i_top_count,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_valid,
    output logic [31:0]       o_entry_addr,
    output logic [31:0]       o_entry_count,
    output logic              o_out_of_range,
    output logic              o_last
);

    logic [31:0]      r_base, r_limit, r_pc;
    logic             r_op;
    logic [KC_W-1:0]  r_n;
    logic [31:0]      r_cnt, r_cur;
    logic [ENT_W-1:0] r_best, r_aent;
    logic             r_valid, r_oor, r_last;
    logic [31:0]      r_oaddr, r_ocnt;

    logic [31:0]      diff;
    logic [HW_AW-1:0] h_addr;
    logic [31:0]      h_wdata, h_q;
    logic [ENT_W-1:0] k_wdata, k_q;
    logic [32:0]      scan_addr;

    assign diff      = r_pc - r_base;
    assign scan_addr = {1'b0, r_base} + 33'({i_cmd.ctr, 2'b00});
    assign h_addr    = i_cmd.hist_scan ? i_cmd.ctr[HW_AW-1:0] : diff[HW_AW+1:2];
    assign h_wdata   = i_cmd.hist_clear ? 32'd0 :
                       ((h_q == 32'hFFFF_FFFF) ? h_q : h_q + 32'd1);

    always_comb begin
        unique case (i_cmd.wsel)
            W_CUR:   k_wdata = {r_cur, r_cnt};
            W_BEST:  k_wdata = r_best;
            W_AENT:  k_wdata = r_aent;
            default: k_wdata = {r_cur, r_cnt};
        endcase
    end

    pcst_ram #(.W(32), .D(HIST_WORDS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.hist_we),
        .i_addr  (h_addr),
        .i_wdata (h_wdata),
        .o_rdata (h_q)
    );

    pcst_ram #(.W(ENT_W), .D(KEPT_DEPTH)) u_kept (
        .i_clk   (i_clk),
        .i_we    (i_cmd.kept_we),
        .i_addr  (i_cmd.kaddr),
        .i_wdata (k_wdata),
        .o_rdata (k_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 32'd0;
            r_limit <= LIMIT_RST;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == CFG_BASE) begin
                r_base <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == CFG_LIMIT) begin
                r_limit <= i_cfg_data;
            end
            r_valid <= i_cmd.emit_oor | i_cmd.emit_entry;
        end
        if (i_cmd.ld_item) begin
            r_op <= i_op;
            r_pc <= i_sample_addr;
            r_n  <= (i_top_count > 7'(TOP_MAX)) ? KC_W'(TOP_MAX) : KC_W'(i_top_count);
        end
        if (i_cmd.cnt_ld) begin
            r_cnt <= h_q;
            r_cur <= scan_addr[31:0];
        end
        if (i_cmd.best_ld) begin
            r_best <= k_q;
        end
        if (i_cmd.a_ld) begin
            r_aent <= k_q;
        end
        if (i_cmd.emit_oor) begin
            r_oaddr <= r_pc;
            r_ocnt  <= 32'd0;
            r_oor   <= 1'b1;
            r_last  <= 1'b1;
        end else if (i_cmd.emit_entry) begin
            r_oaddr <= r_best[63:32];
            r_ocnt  <= r_best[31:0];
            r_oor   <= 1'b0;
            r_last  <= i_cmd.emit_last;
        end
    end

    assign o_sts.is_dump     = r_op;
    assign o_sts.in_range    = (r_pc >= r_base) && (r_pc < r_limit) &&
                               ({2'b00, diff[31:2]} < 32'(HIST_WORDS));
    assign o_sts.n           = r_n;
    assign o_sts.cnt_zero    = (r_cnt == 32'd0);
    assign o_sts.scan_end    = (i_cmd.ctr == HW_CW'(HIST_WORDS)) ||
                               (scan_addr >= {1'b0, r_limit});
    assign o_sts.q_lt_best   = k_q[31:0] < r_best[31:0];
    assign o_sts.q_gt_best   = k_q[31:0] > r_best[31:0];
    assign o_sts.cur_gt_best = r_cnt > r_best[31:0];

    assign o_valid        = r_valid;
    assign o_entry_addr   = r_oaddr;
    assign o_entry_count  = r_ocnt;
    assign o_out_of_range = r_oor;
    assign o_last         = r_last;

endmodule

[rtl/core/pcst_ctrl.sv]
// ============================================================================
// pcst_ctrl: profiler controller
// Sequences clear pass, sample update, top-entry scan and sort.
// ============================================================================
module pcst_ctrl
    import pcst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_INC, S_D_RD, S_D_CHK, S_D_KEEP,
        S_M_RD, S_M_CMP, S_M_DEC, S_T_RD, S_T_CMP, S_T_W1, S_T_W2
    } t_state;

    t_state           r_state, n_state;
    logic [HW_CW-1:0] r_ctr, n_ctr;
    logic [KC_W-1:0]  r_used, n_used, r_a, n_a, r_b, n_b;
    logic [KP_AW-1:0] r_mi, n_mi, r_mx, n_mx;
    logic             r_busy;
    t_cmd             cmd;

    always_comb begin
        n_state = r_state;
        n_ctr   = r_ctr;
        n_used  = r_used;
        n_a     = r_a;
        n_b     = r_b;
        n_mi    = r_mi;
        n_mx    = r_mx;
        cmd     = '0;
        cmd.ctr = r_ctr;
        cmd.wsel = W_CUR;
        unique case (r_state)
            S_CLEAR: begin
                cmd.hist_we    = 1'b1;
                cmd.hist_scan  = 1'b1;
                cmd.hist_clear = 1'b1;
                if (r_ctr == HW_CW'(HIST_WORDS - 1)) begin
                    n_ctr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ctr = r_ctr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    cmd.ld_item = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.is_dump) begin
                    if (i_sts.in_range) begin
                        n_state = S_INC;
                    end else begin
                        cmd.emit_oor = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (i_sts.n == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_ctr   = '0;
                    n_used  = '0;
                    n_state = S_D_RD;
                end
            end
            S_INC: begin
                cmd.hist_we = 1'b1;
                n_state     = S_IDLE;
            end
            S_D_RD: begin
                cmd.hist_scan = 1'b1;
                if (i_sts.scan_end) begin
                    n_a     = '0;
                    n_b     = '0;
                    n_state = (r_used != '0) ? S_T_RD : S_IDLE;
                end else begin
                    n_state = S_D_CHK;
                end
            end
            S_D_CHK: begin
                cmd.hist_scan = 1'b1;
                cmd.cnt_ld    = 1'b1;
                n_state       = S_D_KEEP;
            end
            S_D_KEEP: begin
                cmd.hist_scan = 1'b1;
                if (i_sts.cnt_zero) begin
                    n_ctr   = r_ctr + 1'b1;
                    n_state = S_D_RD;
                end else if (r_used < i_sts.n) begin
                    cmd.kept_we = 1'b1;
                    cmd.kaddr   = r_used[KP_AW-1:0];
                    n_used      = r_used + 1'b1;
                    n_ctr       = r_ctr + 1'b1;
                    n_state     = S_D_RD;
                end else begin
                    n_b     = '0;
                    n_state = S_M_RD;
                end
            end
            S_M_RD: begin
                cmd.kaddr = r_b[KP_AW-1:0];
                n_state   = S_M_CMP;
            end
            S_M_CMP: begin
                cmd.kaddr = r_b[KP_AW-1:0];
                if (r_b == '0 || i_sts.q_lt_best) begin
                    cmd.best_ld = 1'b1;
                    n_mi        = r_b[KP_AW-1:0];
                end
                if (r_b + 1'b1 < r_used) begin
                    n_b     = r_b + 1'b1;
                    n_state = S_M_RD;
                end else begin
                    n_state = S_M_DEC;
                end
            end
            S_M_DEC: begin
                if (i_sts.cur_gt_best) begin
                    cmd.kept_we = 1'b1;
                    cmd.kaddr   = r_mi;
                end
                n_ctr   = r_ctr + 1'b1;
                n_state = S_D_RD;
            end
            S_T_RD: begin
                cmd.kaddr = r_b[KP_AW-1:0];
                n_state   = S_T_CMP;
            end
            S_T_CMP: begin
                cmd.kaddr = r_b[KP_AW-1:0];
                if (r_b == r_a) begin
                    cmd.a_ld    = 1'b1;
                    cmd.best_ld = 1'b1;
                    n_mx        = r_b[KP_AW-1:0];
                end else if (i_sts.q_gt_best) begin
                    cmd.best_ld = 1'b1;
                    n_mx        = r_b[KP_AW-1:0];
                end
                if (r_b + 1'b1 < r_used) begin
                    n_b     = r_b + 1'b1;
                    n_state = S_T_RD;
                end else begin
                    n_state = S_T_W1;
                end
            end
            S_T_W1: begin
                cmd.kept_we    = 1'b1;
                cmd.kaddr      = r_a[KP_AW-1:0];
                cmd.wsel       = W_BEST;
                cmd.emit_entry = 1'b1;
                cmd.emit_last  = (r_a + 1'b1 == r_used);
                n_state        = S_T_W2;
            end
            S_T_W2: begin
                cmd.kept_we = 1'b1;
                cmd.kaddr   = r_mx;
                cmd.wsel    = W_AENT;
                if (r_a + 1'b1 == r_used) begin
                    n_state = S_IDLE;
                end else begin
                    n_a     = r_a + 1'b1;
                    n_b     = r_a + 1'b1;
                    n_state = S_T_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ctr   <= '0;
            r_used  <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_mi    <= '0;
            r_mx    <= '0;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ctr   <= n_ctr;
            r_used  <= n_used;
            r_a     <= n_a;
            r_b     <= n_b;
            r_mi    <= n_mi;
            r_mx    <= n_mx;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= KC_W'(KEPT_DEPTH))
        else $error("kept set overflow");
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_entry |-> (r_used != '0) && (r_a < r_used))
        else $error("emit outside kept set");
    a_swap_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T_W1) |=> (r_state == S_T_W2) && $stable(r_a))
        else $error("swap write pair broken");
    a_busy_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy out of step with state");
`endif

endmodule
